// File: rtl/srr_pkg.sv
package srr_pkg;

   // Fixed field widths of the channels.
   localparam int SEQ_W         = 32;
   localparam int HANDLE_W      = 16;
   localparam int ADVERT_W      = 16;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_INDEX_W   = 1;
   // Widest slot offset that the largest supported window needs.
   localparam int OFS_MAX_W     = 10;

   // Defaults of the top-level parameters.
   localparam int WINDOW_DEFAULT      = 32;
   localparam int HANDLE_BITS_DEFAULT = 16;

   // Depth of the command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Reset value of the advertised window base.
   localparam logic [ADVERT_W-1:0] ADVERT_RESET = 16'd1024;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ADVERT_BASE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_SEQ   = 1'd1;

   // Result kinds.
   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

   // Disposition codes.
   localparam logic [1:0] DISP_ACCEPTED = 2'd0;
   localparam logic [1:0] DISP_OLD_DUP  = 2'd1;
   localparam logic [1:0] DISP_HELD_DUP = 2'd2;
   localparam logic [1:0] DISP_BEYOND   = 2'd3;

   // Classes that the front assigns to a segment.
   localparam logic [1:0] CLS_OLD    = 2'd0;
   localparam logic [1:0] CLS_BEYOND = 2'd1;
   localparam logic [1:0] CLS_INWIN  = 2'd2;

   typedef struct packed {
      logic [SEQ_W-1:0]    seq_number;
      logic [HANDLE_W-1:0] payload_handle;
   } req_type;

   typedef struct packed {
      logic                kind;
      logic [HANDLE_W-1:0] delivered_handle;
      logic [SEQ_W-1:0]    ack_number;
      logic [ADVERT_W-1:0] window_advert;
      logic [1:0]          disposition;
      logic                last;
   } rsp_type;

   // Classified segment handed from the front to the back.
   typedef struct packed {
      logic [1:0]           cls;
      logic [OFS_MAX_W-1:0] offset;
      logic [HANDLE_W-1:0]  handle;
   } cmd_type;

   // What the back reports to the front.
   typedef struct packed {
      logic             idle;
      logic [SEQ_W-1:0] expected_seq;
   } back_status_type;

endpackage

// File: rtl/selective_repeat_receive_reorder_core.sv
// Selective-repeat receiver with an in-order release buffer.
//
// Request channel (req_valid, req_stall, req_data): one transaction is one
// arriving segment, a sequence number and a payload handle. Response channel
// (rsp_valid, rsp_stall, rsp_data): one transaction per released handle, in
// sequence order, then one acknowledgement with last set that carries the
// next expected number and the advertised window.
// Configuration (csr_write_en, csr_index, csr_wdata): index 0 sets the window
// base, index 1 sets a new start number and restarts the receiver.
//
// Steps: a segment is registered in the front, queued, applied in the back and
// followed by a check of the head slot before its acknowledgement; each
// released handle adds a head-slot check and a store read. The next segment
// is taken once the back has finished.
// Reset clears all held slots, sets the expected number to zero and the
// window base to 1024. A stall on the response channel holds the result in
// the output register and the release walk waits; the request channel stalls
// until the walk completes.
module selective_repeat_receive_reorder_core
   import srr_pkg::*;
#(
   parameter int WINDOW      = WINDOW_DEFAULT,
   parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   back_status_type status;
   logic            push_valid;
   cmd_type         push_data;
   logic            q_valid;
   cmd_type         q_data;
   logic            q_pop;

   // Front: takes segments and classifies them against the window.
   srr_front #(
      .WINDOW (WINDOW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .status     (status),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Command queue between the two halves.
   srr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop_valid  (q_valid),
      .pop_data   (q_data),
      .pop_ready  (q_pop)
   );

   // Back: stores segments, releases the in-order run, acknowledges.
   srr_back #(
      .WINDOW      (WINDOW),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_valid      (q_valid),
      .q_data       (q_data),
      .q_pop        (q_pop),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

// File: rtl/srr_front.sv
module srr_front
   import srr_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type         req_data,
   input  back_status_type status,
   output logic            push_valid,
   output cmd_type         push_data
);

   localparam int IDX_BITS = $clog2(WINDOW);
   localparam logic [SEQ_W-1:0] WIN_SEQ = SEQ_W'(WINDOW);

   logic             in_valid_ff, in_valid_in;
   req_type          in_data_ff, in_data_in;
   logic [SEQ_W-1:0] seq_gap;

   // A new transaction is taken only when nothing is in flight.
   assign req_stall = in_valid_ff | ~status.idle;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (in_valid_ff) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_data_ff <= in_data_in;
   end

   // Classify by the modular distance from the expected sequence number.
   assign seq_gap = in_data_ff.seq_number - status.expected_seq;

   always_comb begin
      push_data.handle = in_data_ff.payload_handle;
      push_data.offset = OFS_MAX_W'(seq_gap[IDX_BITS-1:0]);
      priority if (seq_gap[SEQ_W-1]) begin
         push_data.cls = CLS_OLD;
      end else if (seq_gap >= WIN_SEQ) begin
         push_data.cls = CLS_BEYOND;
      end else begin
         push_data.cls = CLS_INWIN;
      end
   end

   assign push_valid = in_valid_ff;

`ifndef SYNTH
   // The expected number used for classification must be final.
   a_classify_when_idle: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> status.idle)
      else $error("segment classified while the back is still working");
`endif

endmodule

// File: rtl/srr_queue.sv
module srr_queue
   import srr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_data,
   output logic    pop_valid,
   output cmd_type pop_data,
   input  logic    pop_ready
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid;
   assign do_pop    = pop_valid & pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (count_ff < CNT_BITS'(QUEUE_DEPTH)))
      else $error("command queue overflow");
`endif

endmodule

// File: rtl/srr_back.sv
module srr_back
   import srr_pkg::*;
#(
   parameter int WINDOW      = WINDOW_DEFAULT,
   parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   q_valid,
   input  cmd_type                q_data,
   output logic                   q_pop,
   output back_status_type        status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data
);

   localparam int IDX_BITS = $clog2(WINDOW);
   localparam int CNT_BITS = $clog2(WINDOW + 1);
   localparam int HB       = (HANDLE_BITS > HANDLE_W) ? HANDLE_W : HANDLE_BITS;
   localparam logic [IDX_BITS:0]   WIN_EXT   = (IDX_BITS + 1)'(WINDOW);
   localparam logic [IDX_BITS-1:0] LAST_SLOT = IDX_BITS'(WINDOW - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_APPLY = 5'b00010,
      ST_LOOK  = 5'b00100,
      ST_READ  = 5'b01000,
      ST_ACK   = 5'b10000
   } back_state_type;

   back_state_type      state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [1:0]          disp_ff, disp_in;
   logic [SEQ_W-1:0]    expected_ff, expected_in;
   logic [IDX_BITS-1:0] head_ff, head_in;
   logic [CNT_BITS-1:0] held_count_ff, held_count_in;
   logic [WINDOW-1:0]   present_ff, present_in;
   logic [ADVERT_W-1:0] advert_ff, advert_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [HB-1:0]       held_mem [WINDOW];
   logic [HB-1:0]       rd_handle_ff;
   logic                mem_we, mem_re;

   logic [IDX_BITS:0]   slot_sum;
   logic [IDX_BITS-1:0] slot;
   logic                out_free;
   logic [ADVERT_W-1:0] held_ext;
   logic [ADVERT_W-1:0] window_now;

   // Ring slot of the segment's offset from the head.
   assign slot_sum = {1'b0, head_ff} + {1'b0, cmd_ff.offset[IDX_BITS-1:0]};
   assign slot     = (slot_sum >= WIN_EXT) ? IDX_BITS'(slot_sum - WIN_EXT)
                                           : slot_sum[IDX_BITS-1:0];

   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign held_ext   = ADVERT_W'(held_count_ff);
   assign window_now = (held_ext > advert_ff) ? '0 : advert_ff - held_ext;

   // Sequencer: apply the segment, walk the run of held entries, then acknowledge.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      disp_in       = disp_ff;
      expected_in   = expected_ff;
      head_in       = head_ff;
      held_count_in = held_count_ff;
      present_in    = present_ff;
      advert_in     = advert_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            priority if (cmd_ff.cls == CLS_OLD) begin
               disp_in = DISP_OLD_DUP;
            end else if (cmd_ff.cls == CLS_BEYOND) begin
               disp_in = DISP_BEYOND;
            end else if (present_ff[slot]) begin
               disp_in = DISP_HELD_DUP;
            end else begin
               disp_in          = DISP_ACCEPTED;
               mem_we           = 1'b1;
               present_in[slot] = 1'b1;
               held_count_in    = held_count_ff + 1'b1;
            end
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (present_ff[head_ff]) begin
               mem_re   = 1'b1;
               state_in = ST_READ;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.kind             = KIND_DELIVER;
               rsp_data_in.delivered_handle = HANDLE_W'(rd_handle_ff);
               rsp_data_in.ack_number       = expected_ff;
               rsp_data_in.window_advert    = '0;
               rsp_data_in.disposition      = disp_ff;
               rsp_data_in.last             = 1'b0;
               present_in[head_ff]          = 1'b0;
               held_count_in                = held_count_ff - 1'b1;
               expected_in                  = expected_ff + 1'b1;
               head_in  = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_ACK: begin
            if (out_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.kind             = KIND_ACK;
               rsp_data_in.delivered_handle = '0;
               rsp_data_in.ack_number       = expected_ff;
               rsp_data_in.window_advert    = window_now;
               rsp_data_in.disposition      = disp_ff;
               rsp_data_in.last             = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register writes; a new start number also restarts the receiver.
      if (csr_write_en) begin
         if (csr_index == CSR_ADVERT_BASE) begin
            advert_in = csr_wdata[ADVERT_W-1:0];
         end else if (csr_index == CSR_START_SEQ) begin
            expected_in   = csr_wdata[SEQ_W-1:0];
            present_in    = '0;
            held_count_in = '0;
            head_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         expected_ff   <= '0;
         head_ff       <= '0;
         held_count_ff <= '0;
         present_ff    <= '0;
         advert_ff     <= ADVERT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         expected_ff   <= expected_in;
         head_ff       <= head_in;
         held_count_ff <= held_count_in;
         present_ff    <= present_in;
         advert_ff     <= advert_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      disp_ff     <= disp_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Held handle store with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         held_mem[slot] <= cmd_ff.handle[HB-1:0];
      end
      if (mem_re) begin
         rd_handle_ff <= held_mem[head_ff];
      end
   end

   assign status.idle         = (state_ff == ST_IDLE) & ~q_valid;
   assign status.expected_seq = expected_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data            = rsp_data_ff;

`ifndef SYNTH
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      held_count_ff == CNT_BITS'($countones(present_ff)))
      else $error("held count disagrees with the present bits");

   a_read_present: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> present_ff[head_ff])
      else $error("release of a slot that holds no handle");

   a_ack_ends_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACK) |-> !present_ff[head_ff])
      else $error("acknowledgement sent while the head slot is still held");
`endif

endmodule
